[sv/sat_pkg.sv]
// Shared types and constants for the summed-area table block.
package sat_pkg;

  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned COORD_W   = 6;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned OUT_W     = 48;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_BUILD = 2'd2,
    ACT_QUERY = 2'd3
  } sat_action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } sat_cfg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_BUILD,
    ST_BDRAIN,
    ST_QUERY,
    ST_QWAIT
  } sat_state_e;

  // tag that follows a query read through the memory latency
  typedef struct packed {
    logic vld;
    logic use_term;
    logic neg;
  } sat_term_t;

endpackage

[sv/sat_ram.sv]
// Simple dual-port RAM: one write port, one registered read port.
module sat_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-during-write to the same entry returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/summed_area_table.sv]
// Top level of the summed-area table: cell store, integral store and sequencer.
//
// Usage: a command word is taken on a clock edge with start high and busy low.
// action_i selects write cell, add to cell, rebuild, or query rectangle.
// A write goes straight into the cell RAM; an add reads the cell, then writes
// it back through the cell RAM. Rebuild walks the configured rows x columns
// one entry per cycle through the integral RAM, then drains its last write.
// A query reads four integral entries through one RAM read port; done_o
// pulses with rect_sum_o as busy falls, after the four reads and a wait state.
// Only queries produce a result word; it is shown for one cycle, the
// receiver cannot stall it. A new command may be taken in the done_o cycle.
// Registers rows_in_use (index 0) and cols_in_use (index 1) are written
// through cfg_we_i/cfg_index_i/cfg_data_i, taken at once; write them idle.
// After reset both RAMs are zeroed by a sweep over all MAX_ROWS*MAX_COLS
// entries (4096 at the defaults) with busy high; config writes still work then.
module summed_area_table
  import sat_pkg::*;
#(
  parameter int unsigned MAX_ROWS  = 64,
  parameter int unsigned MAX_COLS  = 64,
  parameter int unsigned SUM_WIDTH = 48
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [ACTION_W-1:0]       action_i,
  input  logic [COORD_W-1:0]        row_i,
  input  logic [COORD_W-1:0]        col_i,
  input  logic [COORD_W-1:0]        end_row_i,
  input  logic [COORD_W-1:0]        end_col_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  output logic                      done_o,
  output logic signed [OUT_W-1:0]   rect_sum_o
);

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RCW   = (RW > CFG_W) ? RW : CFG_W;
  localparam int unsigned CCW   = (CW > CFG_W) ? CW : CFG_W;

  typedef struct packed {
    logic          vld;
    logic          first_row;
    logic          first_col;
    logic          fwd;
    logic [AW-1:0] addr;
  } bstage_t;

  function automatic logic [AW-1:0] grid_addr(input logic [31:0] r, input logic [31:0] c);
    return AW'(r * 32'(MAX_COLS) + c);
  endfunction

  sat_state_e state_q, state_d;

  logic [CFG_W-1:0] rows_q, cols_q, rows_lim, cols_lim;
  logic [AW-1:0]    clr_q;
  logic             clr_last;
  logic             accept;
  sat_action_e      act;
  logic             in_inside;
  logic [AW-1:0]    in_addr;

  logic [AW-1:0]      op_addr_q;
  logic [VALUE_W-1:0] op_val_q;

  // memory ports
  logic                 c_we, i_we;
  logic [AW-1:0]        c_waddr, c_raddr, i_waddr, i_raddr;
  logic [VALUE_W-1:0]   c_wdata, c_rdata;
  logic [SUM_WIDTH-1:0] i_wdata, i_rdata;

  // rebuild walk
  logic [RW-1:0]        b_row_q;
  logic [CW-1:0]        b_col_q;
  logic                 b_row_last, b_col_last;
  logic [AW-1:0]        b_addr, b_up_addr;
  bstage_t              bs_q, bs_d;
  logic [SUM_WIDTH-1:0] bs_fwd_q, left_q, diag_q;
  logic [SUM_WIDTH-1:0] b_cell_ext, b_above, b_left, b_diag, b_sum;

  // query
  logic [COORD_W-1:0]          sr_q, sc_q, er_q, ec_q;
  logic                        q_empty_q;
  logic [1:0]                  q_cnt_q;
  sat_term_t                   qt_q, qt_d;
  logic [COORD_W-1:0]          q_row, q_col;
  logic [AW-1:0]               q_addr;
  logic [SUM_WIDTH-1:0]        q_term;
  logic signed [SUM_WIDTH-1:0] acc_q, acc_d;
  logic signed [OUT_W-1:0]     rect_sum_q;
  logic                        done_q;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign act      = sat_action_e'(action_i);
  assign rows_lim = (32'(rows_q) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : rows_q;
  assign cols_lim = (32'(cols_q) > MAX_COLS) ? CFG_W'(MAX_COLS) : cols_q;
  assign clr_last = (clr_q == AW'(DEPTH - 1));

  assign in_inside = (32'(row_i) < MAX_ROWS) && (32'(col_i) < MAX_COLS);
  assign in_addr   = grid_addr(32'(row_i), 32'(col_i));

  assign b_row_last = (RCW'(b_row_q) == RCW'(rows_lim - CFG_W'(1)));
  assign b_col_last = (CCW'(b_col_q) == CCW'(cols_lim - CFG_W'(1)));
  assign b_addr     = grid_addr(32'(b_row_q), 32'(b_col_q));
  assign b_up_addr  = (b_row_q == '0) ? '0 :
                      grid_addr(32'(b_row_q) - 32'd1, 32'(b_col_q));

  // entry = cell + above + left - diagonal, mod 2^SUM_WIDTH
  assign b_cell_ext = SUM_WIDTH'($signed(c_rdata));
  assign b_above    = bs_q.first_row ? '0 : (bs_q.fwd ? bs_fwd_q : i_rdata);
  assign b_left     = bs_q.first_col ? '0 : left_q;
  assign b_diag     = (bs_q.first_row || bs_q.first_col) ? '0 : diag_q;
  assign b_sum      = b_cell_ext + b_above + b_left - b_diag;

  always_comb begin
    bs_d.vld       = (state_q == ST_BUILD);
    bs_d.first_row = (b_row_q == '0);
    bs_d.first_col = (b_col_q == '0);
    // above entry still being written this cycle (single-column walk)
    bs_d.fwd       = (state_q == ST_BUILD) && bs_q.vld && (bs_q.addr == b_up_addr) &&
                     (b_row_q != '0);
    bs_d.addr      = b_addr;
  end

  // query terms: D - C - B + A over the integral table
  always_comb begin
    q_row         = er_q;
    q_col         = ec_q;
    qt_d.use_term = 1'b1;
    qt_d.neg      = 1'b0;
    unique case (q_cnt_q)
      2'd0: begin
        q_row = er_q;
        q_col = ec_q;
      end
      2'd1: begin
        q_row         = er_q;
        q_col         = sc_q - COORD_W'(1);
        qt_d.use_term = (sc_q != '0);
        qt_d.neg      = 1'b1;
      end
      2'd2: begin
        q_row         = sr_q - COORD_W'(1);
        q_col         = ec_q;
        qt_d.use_term = (sr_q != '0);
        qt_d.neg      = 1'b1;
      end
      default: begin
        q_row         = sr_q - COORD_W'(1);
        q_col         = sc_q - COORD_W'(1);
        qt_d.use_term = (sr_q != '0) && (sc_q != '0);
      end
    endcase
    // entries outside the grid read as zero
    if (!((32'(q_row) < MAX_ROWS) && (32'(q_col) < MAX_COLS))) begin
      qt_d.use_term = 1'b0;
    end
    qt_d.vld = (state_q == ST_QUERY);
  end

  assign q_addr = grid_addr(32'(q_row), 32'(q_col));
  assign q_term = qt_q.use_term ? i_rdata : '0;

  always_comb begin
    acc_d = acc_q;
    if (qt_q.vld) begin
      acc_d = qt_q.neg ? (acc_q - $signed(q_term)) : (acc_q + $signed(q_term));
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          unique case (act)
            ACT_WRITE: state_d = ST_IDLE;
            ACT_ADD:   if (in_inside) state_d = ST_ADD;
            ACT_BUILD: if ((rows_lim != '0) && (cols_lim != '0)) state_d = ST_BUILD;
            ACT_QUERY: state_d = ST_QUERY;
          endcase
        end
      end
      ST_ADD:    state_d = ST_IDLE;
      ST_BUILD: begin
        if (b_row_last && b_col_last) state_d = ST_BDRAIN;
      end
      ST_BDRAIN: state_d = ST_IDLE;
      ST_QUERY: begin
        if (q_cnt_q == 2'd3) state_d = ST_QWAIT;
      end
      ST_QWAIT:  state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    c_we    = 1'b0;
    c_waddr = in_addr;
    c_wdata = value_i;
    c_raddr = in_addr;
    i_we    = bs_q.vld;
    i_waddr = bs_q.addr;
    i_wdata = b_sum;
    i_raddr = q_addr;
    unique case (state_q)
      ST_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = clr_q;
        c_wdata = '0;
        i_we    = 1'b1;
        i_waddr = clr_q;
        i_wdata = '0;
      end
      ST_IDLE: begin
        c_we = start && (act == ACT_WRITE) && in_inside;
      end
      ST_ADD: begin
        c_we    = 1'b1;
        c_waddr = op_addr_q;
        c_wdata = c_rdata + op_val_q;
      end
      ST_BUILD: begin
        c_raddr = b_addr;
        i_raddr = b_up_addr;
      end
      default: begin
      end
    endcase
  end

  sat_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  sat_ram #(
    .WIDTH (SUM_WIDTH),
    .DEPTH (DEPTH)
  ) u_integral_ram (
    .clk_i   (clk_i),
    .we_i    (i_we),
    .waddr_i (i_waddr),
    .wdata_i (i_wdata),
    .raddr_i (i_raddr),
    .rdata_o (i_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      rows_q  <= CFG_RESET;
      cols_q  <= CFG_RESET;
      b_row_q <= '0;
      b_col_q <= '0;
      bs_q    <= '0;
      q_cnt_q <= '0;
      qt_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      bs_q    <= bs_d;
      qt_q    <= qt_d;
      done_q  <= (state_q == ST_QWAIT);
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cfg_we_i) begin
        unique case (sat_cfg_e'(cfg_index_i))
          CFG_ROWS: rows_q <= cfg_data_i;
          CFG_COLS: cols_q <= cfg_data_i;
        endcase
      end
      if (accept && (act == ACT_BUILD)) begin
        b_row_q <= '0;
        b_col_q <= '0;
      end else if (state_q == ST_BUILD) begin
        if (b_col_last) begin
          b_col_q <= '0;
          b_row_q <= b_row_q + RW'(1);
        end else begin
          b_col_q <= b_col_q + CW'(1);
        end
      end
      if (accept && (act == ACT_QUERY)) begin
        q_cnt_q <= '0;
      end else if (state_q == ST_QUERY) begin
        q_cnt_q <= q_cnt_q + 2'd1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_addr_q <= in_addr;
      op_val_q  <= value_i;
      sr_q      <= row_i;
      sc_q      <= col_i;
      er_q      <= end_row_i;
      ec_q      <= end_col_i;
      q_empty_q <= (end_row_i < row_i) || (end_col_i < col_i);
    end
    if (bs_q.vld) begin
      left_q <= b_sum;
      diag_q <= b_above;
    end
    bs_fwd_q <= b_sum;
    if (accept && (act == ACT_QUERY)) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
    if (state_q == ST_QWAIT) begin
      rect_sum_q <= q_empty_q ? '0 : OUT_W'(acc_d);
    end
  end

  assign done_o     = done_q;
  assign rect_sum_o = rect_sum_q;

  a_query_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (act == ACT_QUERY)) |-> ##6 done_o)
    else $error("query result not delivered on time");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result word while sequencer busy");

  a_fwd_single_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bs_q.fwd |-> (bs_q.vld && (cols_lim == CFG_W'(1))))
    else $error("forward taken outside single-column rebuild");

  a_stage_in_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bs_q.vld |-> ((state_q == ST_BUILD) || (state_q == ST_BDRAIN)))
    else $error("rebuild write outside rebuild");

endmodule

[tb/testbench.sv]
// Self-checking testbench for summed_area_table: corner words, register limits, random traffic.
`timescale 1ns / 1ps

module testbench;
  import sat_pkg::*;

  localparam int GRID_N      = 64;
  localparam int CYCLE_LIMIT = 300_000;

  typedef struct {
    logic [COORD_W-1:0] r0, c0, r1, c1;
    logic [OUT_W-1:0]   sum;
  } rect_due_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [ACTION_W-1:0] action_i;
  logic [COORD_W-1:0]  row_i, col_i, end_row_i, end_col_i;
  logic [VALUE_W-1:0]  value_i;
  logic                cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]    cfg_data_i;
  logic                done_o;
  logic [OUT_W-1:0]    rect_sum_o;

  // shadow of the block: cell grid, integral table, area registers
  logic [VALUE_W-1:0]  grid_cells [GRID_N*GRID_N];
  logic [OUT_W-1:0]    grid_sums  [GRID_N*GRID_N];
  logic [CFG_W-1:0]    rows_cfg, cols_cfg;
  rect_due_t           sums_due [$];

  int n_mismatch, n_cycles, n_words, n_cell_ops, n_builds, n_queries;

  summed_area_table i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .action_i    (action_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .end_row_i   (end_row_i),
    .end_col_i   (end_col_i),
    .value_i     (value_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .rect_sum_o  (rect_sum_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d sums outstanding", n_cycles, sums_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    n_mismatch++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  function automatic logic [OUT_W-1:0] sum_at(int r, int c);
    return grid_sums[r*GRID_N + c];
  endfunction

  function automatic void rebuild_sums();
    int nr, nc;
    logic [VALUE_W-1:0] cell_val;
    logic [OUT_W-1:0] s;
    nr = (rows_cfg > GRID_N) ? GRID_N : rows_cfg;
    nc = (cols_cfg > GRID_N) ? GRID_N : cols_cfg;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        cell_val = grid_cells[r*GRID_N + c];
        s = {{(OUT_W-VALUE_W){cell_val[VALUE_W-1]}}, cell_val};
        if (r > 0) s += sum_at(r - 1, c);
        if (c > 0) s += sum_at(r, c - 1);
        if (r > 0 && c > 0) s -= sum_at(r - 1, c - 1);
        grid_sums[r*GRID_N + c] = s;
      end
    end
  endfunction

  function automatic logic [OUT_W-1:0] rect_sum_of(int r0, int c0, int r1, int c1);
    logic [OUT_W-1:0] s;
    if (r1 < r0 || c1 < c0) return '0;
    s = sum_at(r1, c1);
    if (c0 > 0) s -= sum_at(r1, c0 - 1);
    if (r0 > 0) s -= sum_at(r0 - 1, c1);
    if (r0 > 0 && c0 > 0) s += sum_at(r0 - 1, c0 - 1);
    return s;
  endfunction

  function automatic void apply_word(sat_action_e act, logic [COORD_W-1:0] r, c, er, ec,
                                     logic [VALUE_W-1:0] v);
    rect_due_t due;
    n_words++;
    case (act)
      ACT_WRITE: begin
        grid_cells[r*GRID_N + c] = v;
        n_cell_ops++;
      end
      ACT_ADD: begin
        grid_cells[r*GRID_N + c] = grid_cells[r*GRID_N + c] + v;
        n_cell_ops++;
      end
      ACT_BUILD: begin
        rebuild_sums();
        n_builds++;
      end
      default: begin
        due = '{r, c, er, ec, rect_sum_of(r, c, er, ec)};
        sums_due.insert(sums_due.size(), due);
      end
    endcase
  endfunction

  // start stays high on return; caller either sends the next word or drops it
  task automatic issue(input sat_action_e act, input logic [COORD_W-1:0] r, c, er, ec,
                       input logic [VALUE_W-1:0] v);
    start     <= 1'b1;
    action_i  <= act;
    row_i     <= r;
    col_i     <= c;
    end_row_i <= er;
    end_col_i <= ec;
    value_i   <= v;
    do @(posedge clk_i); while (busy);
    apply_word(act, r, c, er, ec, v);
  endtask

  task automatic pause_for(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // let writes, adds and rebuilds finish and all sums come back
  task automatic settle();
    start <= 1'b0;
    repeat (3) @(posedge clk_i);
    while (busy || sums_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_area(input logic [CFG_W-1:0] rows, cols);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ROWS;
    cfg_data_i  <= rows;
    @(posedge clk_i);
    rows_cfg = rows;
    cfg_index_i <= CFG_COLS;
    cfg_data_i  <= cols;
    @(posedge clk_i);
    cols_cfg = cols;
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '1;
      3:       return '0;
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk_i) begin : check_sums
    rect_due_t due;
    if (rst_ni && done_o) begin
      if (sums_due.size() == 0) begin
        report_mismatch($sformatf("rect_sum %0d with no query pending", $signed(rect_sum_o)));
      end else begin
        due = sums_due.pop_front();
        n_queries++;
        if (rect_sum_o !== due.sum)
          report_mismatch($sformatf("rows %0d..%0d cols %0d..%0d: got %0d, want %0d",
                                    due.r0, due.r1, due.c0, due.c1,
                                    $signed(rect_sum_o), $signed(due.sum)));
      end
    end
  end

  // full grid at reset size: extreme cells, 32-bit wrap on add, empty rectangles
  task automatic test_corners();
    settle();
    issue(ACT_WRITE, 0, 0, 0, 0, 32'h7fff_ffff);
    issue(ACT_WRITE, 63, 63, 0, 0, 32'h8000_0000);
    issue(ACT_WRITE, 0, 63, 0, 0, 32'hffff_ffff);
    issue(ACT_WRITE, 63, 0, 0, 0, 32'h0000_0001);
    issue(ACT_ADD, 0, 0, 0, 0, 32'h7fff_ffff);
    issue(ACT_ADD, 63, 63, 0, 0, 32'h8000_0000);
    issue(ACT_BUILD, 0, 0, 0, 0, '0);
    issue(ACT_QUERY, 0, 0, 63, 63, '0);
    issue(ACT_QUERY, 0, 0, 0, 0, '0);
    issue(ACT_QUERY, 63, 63, 63, 63, '0);
    issue(ACT_QUERY, 5, 0, 4, 63, '0);
    issue(ACT_QUERY, 0, 5, 63, 4, '0);
    issue(ACT_QUERY, 1, 1, 62, 62, '0);
  endtask

  // zero area, oversize registers, single row and single column rebuilds
  task automatic test_register_limits();
    settle();
    set_area(7'd0, 7'd64);
    issue(ACT_WRITE, 2, 2, 0, 0, 32'd1000);
    issue(ACT_BUILD, 0, 0, 0, 0, '0);
    issue(ACT_QUERY, 0, 0, 63, 63, '0);
    settle();
    set_area(7'd127, 7'd1);
    issue(ACT_ADD, 40, 0, 0, 0, -32'sd7);
    issue(ACT_BUILD, 0, 0, 0, 0, '0);
    issue(ACT_QUERY, 0, 0, 63, 0, '0);
    settle();
    set_area(7'd1, 7'd127);
    issue(ACT_WRITE, 0, 50, 0, 0, 32'h4000_0000);
    issue(ACT_BUILD, 0, 0, 0, 0, '0);
    issue(ACT_QUERY, 0, 40, 5, 63, '0);
    settle();
    set_area(7'd64, 7'd0);
    issue(ACT_BUILD, 0, 0, 0, 0, '0);
    issue(ACT_QUERY, 0, 0, 63, 63, '0);
    settle();
    set_area(7'd64, 7'd64);
    issue(ACT_BUILD, 0, 0, 0, 0, '0);
    issue(ACT_QUERY, 0, 0, 63, 63, '0);
  endtask

  task automatic test_random_traffic(input int idle_pct, input logic [CFG_W-1:0] rows, cols,
                                     input int count);
    int nr, nc, pick, shape;
    logic [COORD_W-1:0] r, c, er, ec;
    settle();
    set_area(rows, cols);
    nr = (rows > GRID_N) ? GRID_N : rows;
    nc = (cols > GRID_N) ? GRID_N : cols;
    for (int i = 0; i < count; i++) begin
      pause_for(idle_pct);
      if (i == count / 2 || $urandom_range(99) < 2) begin
        start <= 1'b0;
        do @(posedge clk_i); while (sums_due.size() != 0);
      end
      r  = COORD_W'($urandom_range(nr - 1));
      c  = COORD_W'($urandom_range(nc - 1));
      er = COORD_W'($urandom_range(63));
      ec = COORD_W'($urandom_range(63));
      if ($urandom_range(99) < 15) begin
        r = COORD_W'($urandom_range(63));
        c = COORD_W'($urandom_range(63));
      end
      pick = $urandom_range(99);
      if (pick < 30) begin
        issue(ACT_WRITE, r, c, er, ec, pick_value());
      end else if (pick < 50) begin
        issue(ACT_ADD, r, c, er, ec, pick_value());
      end else if (pick < 58) begin
        issue(ACT_BUILD, r, c, er, ec, $urandom());
      end else begin
        shape = $urandom_range(9);
        if (shape < 8) begin
          r  = COORD_W'($urandom_range(nr - 1));
          er = COORD_W'($urandom_range(nr - 1, r));
          c  = COORD_W'($urandom_range(nc - 1));
          ec = COORD_W'($urandom_range(nc - 1, c));
        end else if (shape == 8 && pick[0]) begin
          // end row before start row
          r  = COORD_W'($urandom_range(63, 1));
          er = COORD_W'($urandom_range(r - 1));
        end else if (shape == 8) begin
          c  = COORD_W'($urandom_range(63, 1));
          ec = COORD_W'($urandom_range(c - 1));
        end else begin
          r  = COORD_W'($urandom_range(63));
          c  = COORD_W'($urandom_range(63));
        end
        issue(ACT_QUERY, r, c, er, ec, $urandom());
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    action_i    = ACT_WRITE;
    row_i       = '0;
    col_i       = '0;
    end_row_i   = '0;
    end_col_i   = '0;
    value_i     = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_ROWS;
    cfg_data_i  = '0;
    foreach (grid_cells[k]) grid_cells[k] = '0;
    foreach (grid_sums[k]) grid_sums[k] = '0;
    rows_cfg = CFG_RESET;
    cols_cfg = CFG_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_corners();
    test_register_limits();
    test_random_traffic(18, CFG_W'($urandom_range(10, 1)), CFG_W'($urandom_range(10, 1)), 272);
    test_random_traffic(73, 7'd127, CFG_W'($urandom_range(3, 1)), 272);
    test_random_traffic(0, CFG_W'($urandom_range(3, 1)), 7'd64, 272);
    settle();

    $display("ran %0d command words: %0d cell writes/adds, %0d rebuilds, %0d sums checked",
             n_words, n_cell_ops, n_builds, n_queries);
    $display("areas from empty to full grid at three sender idle rates, %0d mismatches",
             n_mismatch);
    if (n_mismatch == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
